// ===== rtl/ppp_pkg.sv =====
`default_nettype none
package ppp_pkg;

  typedef struct packed {
    logic              opcode;
    logic [3:0]        element_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               behind_camera;
  } out_beat_t;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam int SIZE_W = 14;  // viewport registers
  localparam int HALF_W = 13;  // halved viewport size

  localparam int CLIP_W = 50;  // clip coordinate
  localparam int NUM_W  = 65;  // signed numerator
  localparam int MAG_W  = 64;  // numerator magnitude
  localparam int Q_BITS = 16;  // quotient bits per divide

  localparam logic signed [CLIP_W-1:0] W_MIN_RAW = 50'sd6554;  // 0.1 rounded up
  localparam logic signed [15:0] BEHIND_VALUE = -16'sd500;
  localparam logic signed [15:0] SAT_MAX = 16'sd32767;
  localparam logic signed [15:0] SAT_MIN = -16'sd32768;

endpackage
`default_nettype wire

// ===== rtl/perspective_point_projection_unit.sv =====
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | ppp_pkg::in_beat_t
// out_    | output    | out_valid / out_stall| ppp_pkg::out_beat_t
// cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; a projection passes 24 register stages,
// the first loaded at accept and the last driving out_valid:
// 5 transform stages, 1 magnitude stage, 17 divider stages (range check + 16 quotient
// bits), 1 output register. Matrix writes complete at accept and give no result.
// Each stage holds under stall while empty stages still fill (bubbles collapse).
// Synchronous active-low reset clears valid bits and matrix, and sets viewport to 1920 x 1080.
module perspective_point_projection_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ppp_pkg::in_beat_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ppp_pkg::out_beat_t                    out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ppp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ppp_pkg::SIZE_W-1:0]       cfg_data
);

  localparam int NSTG = 24;
  localparam int DIV0 = 7;  // first divider stage

  logic [NSTG:1]   v_r;
  logic [NSTG+1:1] en;
  logic            in_acc;

  logic [15:0][31:0] matrix_r;
  logic [ppp_pkg::SIZE_W-1:0] width_r, height_r;

  logic signed [ppp_pkg::NUM_W-1:0]  num_x, num_y;
  logic signed [ppp_pkg::CLIP_W-1:0] clip_w;
  logic                              behind5;

  logic [ppp_pkg::MAG_W-1:0]  magx_r, magy_r;
  logic [ppp_pkg::CLIP_W-1:0] d6_r;
  logic negx_r, negy_r, bh6_r;

  logic [ppp_pkg::Q_BITS-1:0] quo_x, quo_y;
  logic ovf_x, ovf_y, sign_x, sign_y, behind_d;

  ppp_pkg::out_beat_t out_r, out_nxt;

  assign en[NSTG+1] = !out_stall;
  for (genvar k = 1; k <= NSTG; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign in_stall  = !en[1];
  assign in_acc    = in_valid && en[1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid && (in_data.opcode == ppp_pkg::OP_PROJECT);
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '0;
      width_r  <= 14'd1920;
      height_r <= 14'd1080;
    end else begin
      if (in_acc && in_data.opcode == ppp_pkg::OP_WRITE) begin
        matrix_r[in_data.element_index] <= in_data.coord_x;
      end
      if (cfg_valid) begin
        case (cfg_index)
          ppp_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_data;
          ppp_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  ppp_clip u_clip (
    .clk     (clk),
    .en      (en[5:1]),
    .in_data (in_data),
    .matrix  (matrix_r),
    .half_w  (width_r[ppp_pkg::SIZE_W-1:1]),
    .half_h  (height_r[ppp_pkg::SIZE_W-1:1]),
    .num_x   (num_x),
    .num_y   (num_y),
    .clip_w  (clip_w),
    .behind  (behind5)
  );

  // magnitude and sign for truncation toward zero
  always_ff @(posedge clk) begin
    if (en[6]) begin
      negx_r <= num_x[ppp_pkg::NUM_W-1];
      negy_r <= num_y[ppp_pkg::NUM_W-1];
      magx_r <= num_x[ppp_pkg::NUM_W-1] ? ppp_pkg::MAG_W'(-num_x) : ppp_pkg::MAG_W'(num_x);
      magy_r <= num_y[ppp_pkg::NUM_W-1] ? ppp_pkg::MAG_W'(-num_y) : ppp_pkg::MAG_W'(num_y);
      d6_r   <= clip_w;
      bh6_r  <= behind5;
    end
  end

  ppp_div u_div (
    .clk        (clk),
    .en         (en[DIV0+ppp_pkg::Q_BITS:DIV0]),
    .mag_x      (magx_r),
    .mag_y      (magy_r),
    .divisor    (d6_r),
    .neg_x      (negx_r),
    .neg_y      (negy_r),
    .behind_in  (bh6_r),
    .quo_x      (quo_x),
    .quo_y      (quo_y),
    .ovf_x      (ovf_x),
    .ovf_y      (ovf_y),
    .sign_x     (sign_x),
    .sign_y     (sign_y),
    .behind_out (behind_d)
  );

  function automatic logic signed [15:0] sat_q(input logic [15:0] q, input logic ovf,
                                                input logic neg);
    logic signed [15:0] res;
    if (!neg) begin
      res = (ovf || q > 16'd32767) ? ppp_pkg::SAT_MAX : $signed(q);
    end else begin
      res = (ovf || q > 16'd32768) ? ppp_pkg::SAT_MIN : $signed(-q);
    end
    return res;
  endfunction

  always_comb begin
    out_nxt.behind_camera = behind_d;
    if (behind_d) begin
      out_nxt.screen_x = ppp_pkg::BEHIND_VALUE;
      out_nxt.screen_y = ppp_pkg::BEHIND_VALUE;
    end else begin
      out_nxt.screen_x = sat_q(quo_x, ovf_x, sign_x);
      out_nxt.screen_y = sat_q(quo_y, ovf_y, sign_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[NSTG];
  assign out_data  = out_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r[1] && out_valid && out_stall))
    else $error("input stalled with room in the pipe");

  a_write_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.opcode == ppp_pkg::OP_WRITE) |=> !v_r[1])
    else $error("matrix write entered the pipe");

  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.behind_camera) |->
      (out_data.screen_x == ppp_pkg::BEHIND_VALUE && out_data.screen_y == ppp_pkg::BEHIND_VALUE))
    else $error("behind beat without sentinel");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-1] && out_valid && out_stall) |=> v_r[NSTG-1])
    else $error("stage dropped under stall");

endmodule
`default_nettype wire

// ===== rtl/ppp_clip.sv =====
`default_nettype none
// Clip-space transform and numerator forming: five register stages.
module ppp_clip (
  input  wire logic                                 clk,
  input  wire logic [4:0]                           en,
  input  wire ppp_pkg::in_beat_t                    in_data,
  input  wire logic [15:0][31:0]                    matrix,
  input  wire logic [ppp_pkg::HALF_W-1:0]           half_w,
  input  wire logic [ppp_pkg::HALF_W-1:0]           half_h,
  output logic signed [ppp_pkg::NUM_W-1:0]          num_x,
  output logic signed [ppp_pkg::NUM_W-1:0]          num_y,
  output logic signed [ppp_pkg::CLIP_W-1:0]         clip_w,
  output logic                                      behind
);

  // rows 0, 1 and 3 of the matrix (x, y, w)
  logic signed [63:0] prod_r [3][3];
  logic signed [31:0] tr_r [3];
  logic signed [48:0] sa_r [3];
  logic signed [48:0] sb_r [3];
  logic signed [ppp_pkg::CLIP_W-1:0] c_r [3];
  logic bh3_r;
  logic signed [ppp_pkg::CLIP_W:0] nx_r, ny_r;
  logic signed [ppp_pkg::CLIP_W-1:0] cw4_r, cw5_r;
  logic bh4_r, bh5_r;
  logic signed [ppp_pkg::NUM_W-1:0] px_r, py_r;
  logic signed [31:0] coord [3];

  assign coord[0] = in_data.coord_x;
  assign coord[1] = in_data.coord_y;
  assign coord[2] = in_data.coord_z;

  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam int MROW = (r == 2) ? 3 : r;
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en[0]) begin
          prod_r[r][c] <= coord[c] * $signed(matrix[c*4+MROW]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[0]) begin
        tr_r[r] <= $signed(matrix[12+MROW]);
      end
      if (en[1]) begin
        // >>> 16 is the floor rounding of the Q32.32 product
        sa_r[r] <= 49'(prod_r[r][0] >>> 16) + 49'(prod_r[r][1] >>> 16);
        sb_r[r] <= 49'(prod_r[r][2] >>> 16) + 49'(tr_r[r]);
      end
      if (en[2]) begin
        c_r[r] <= 50'(sa_r[r]) + 50'(sb_r[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      bh3_r <= (50'(sa_r[2]) + 50'(sb_r[2])) < ppp_pkg::W_MIN_RAW;
    end
    if (en[3]) begin
      nx_r  <= 51'(c_r[0]) + 51'(c_r[2]);
      ny_r  <= 51'(c_r[2]) - 51'(c_r[1]);
      cw4_r <= c_r[2];
      bh4_r <= bh3_r;
    end
    if (en[4]) begin
      px_r  <= $signed({1'b0, half_w}) * nx_r;
      py_r  <= $signed({1'b0, half_h}) * ny_r;
      cw5_r <= cw4_r;
      bh5_r <= bh4_r;
    end
  end

  assign num_x  = px_r;
  assign num_y  = py_r;
  assign clip_w = cw5_r;
  assign behind = bh5_r;

endmodule
`default_nettype wire

// ===== rtl/ppp_div.sv =====
`default_nettype none
// Two-lane restoring divider, one quotient bit per stage, plus a range check stage.
module ppp_div (
  input  wire logic                              clk,
  input  wire logic [ppp_pkg::Q_BITS:0]          en,
  input  wire logic [ppp_pkg::MAG_W-1:0]         mag_x,
  input  wire logic [ppp_pkg::MAG_W-1:0]         mag_y,
  input  wire logic [ppp_pkg::CLIP_W-1:0]        divisor,
  input  wire logic                              neg_x,
  input  wire logic                              neg_y,
  input  wire logic                              behind_in,
  output logic [ppp_pkg::Q_BITS-1:0]             quo_x,
  output logic [ppp_pkg::Q_BITS-1:0]             quo_y,
  output logic                                   ovf_x,
  output logic                                   ovf_y,
  output logic                                   sign_x,
  output logic                                   sign_y,
  output logic                                   behind_out
);

  localparam int QB = ppp_pkg::Q_BITS;
  localparam int CW = ppp_pkg::MAG_W + 2;

  logic [ppp_pkg::MAG_W-1:0]  rem_r [QB+1][2];
  logic [QB-1:0]              quo_r [QB+1][2];
  logic                       ovf_r [QB+1][2];
  logic                       neg_r [QB+1][2];
  logic [ppp_pkg::CLIP_W-1:0] d_r   [QB+1];
  logic                       bh_r  [QB+1];
  logic [ppp_pkg::MAG_W-1:0]  mag_in [2];

  assign mag_in[0] = mag_x;
  assign mag_in[1] = mag_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r[0]  <= divisor;
      bh_r[0] <= behind_in;
      neg_r[0][0] <= neg_x;
      neg_r[0][1] <= neg_y;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en[0]) begin
        rem_r[0][l] <= mag_in[l];
        quo_r[0][l] <= '0;
        // quotient does not fit in QB bits
        ovf_r[0][l] <= {2'b00, mag_in[l]} >= (CW'(divisor) << QB);
      end
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int BIT = QB - k;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        d_r[k]  <= d_r[k-1];
        bh_r[k] <= bh_r[k-1];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [CW-1:0] sub;
      logic          fits;
      assign sub  = CW'(d_r[k-1]) << BIT;
      assign fits = {2'b00, rem_r[k-1][l]} >= sub;
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k][l] <= fits ? ppp_pkg::MAG_W'({2'b00, rem_r[k-1][l]} - sub)
                              : rem_r[k-1][l];
          quo_r[k][l] <= quo_r[k-1][l] | (QB'(fits) << BIT);
          ovf_r[k][l] <= ovf_r[k-1][l];
          neg_r[k][l] <= neg_r[k-1][l];
        end
      end
    end
  end

  assign quo_x      = quo_r[QB][0];
  assign quo_y      = quo_r[QB][1];
  assign ovf_x      = ovf_r[QB][0];
  assign ovf_y      = ovf_r[QB][1];
  assign sign_x     = neg_r[QB][0];
  assign sign_y     = neg_r[QB][1];
  assign behind_out = bh_r[QB];

endmodule
`default_nettype wire
